// ===== rtl/core/pai_pkg.sv =====
// Shared types, constants and compare functions for the Pareto archive.
package pai_pkg;

    localparam int CAPACITY  = 32;
    localparam int OBJ_W     = 32;
    localparam int TOUR_W    = 32;
    localparam int NCELL     = CAPACITY + 1;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int IDX_W     = $clog2(NCELL);
    localparam int PTR_W     = $clog2(NCELL + 1);
    localparam int OUT_CNT_W = 6;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_CLEAR  = 1'b1;

    typedef struct packed {
        logic signed [OBJ_W-1:0]  p;
        logic signed [OBJ_W-1:0]  s;
        logic signed [OBJ_W-1:0]  c;
        logic        [TOUR_W-1:0] t;
    } entry_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_PRUNE,
        CELL_SHIFT
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     in_range;
        logic     fill;
    } cell_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INSERT,
        ST_PRUNE,
        ST_FIXUP,
        ST_EMIT
    } state_t;

    // Sort order: primary, secondary, check (signed), then tour id.
    function automatic logic less_than(entry_t a, entry_t b);
        logic r;
        if (a.p != b.p) begin
            r = ($signed(a.p) < $signed(b.p));
        end else if (a.s != b.s) begin
            r = ($signed(a.s) < $signed(b.s));
        end else if (a.c != b.c) begin
            r = ($signed(a.c) < $signed(b.c));
        end else begin
            r = (a.t < b.t);
        end
        return r;
    endfunction

    // True when earlier entry cur knocks out later entry l.
    function automatic logic removes(logic three_obj, entry_t cur, entry_t l);
        logic r;
        if (three_obj) begin
            r = ($signed(l.s) >= $signed(cur.s)) && ($signed(l.c) >= $signed(cur.c));
        end else if (l.p == cur.p) begin
            if (l.s == cur.s) begin
                r = (l.t == cur.t);
            end else begin
                r = ($signed(l.s) > $signed(cur.s));
            end
        end else begin
            r = ($signed(l.s) >= $signed(cur.s));
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/pai_cell.sv =====
// One archive slot: holds an entry, sorts in a new point, prunes and shifts.
module pai_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  pai_pkg::cell_ctl_t ctl,
    input  logic               three_obj,
    input  pai_pkg::entry_t    np,
    input  pai_pkg::entry_t    head,
    input  pai_pkg::entry_t    left_entry,
    input  logic               left_gt,
    input  pai_pkg::entry_t    right_entry,
    input  logic               right_alive,
    output pai_pkg::entry_t    entry,
    output logic               alive,
    output logic               gt,
    output logic               dup
);
    import pai_pkg::*;

    entry_t entry_reg, entry_next;
    logic   alive_reg, alive_next;

    // Empty slots sort after everything.
    assign gt  = !ctl.in_range || less_than(np, entry_reg);
    assign dup = ctl.in_range && (np.p == entry_reg.p) && (np.s == entry_reg.s)
                 && (np.t == entry_reg.t);

    always_comb begin
        entry_next = entry_reg;
        alive_next = alive_reg;
        unique case (ctl.op)
            CELL_INSERT: begin
                if (gt && !left_gt) begin
                    entry_next = np;
                end else if (gt) begin
                    entry_next = left_entry;
                end
                alive_next = ctl.fill;
            end
            CELL_PRUNE: begin
                if (removes(three_obj, head, entry_reg)) begin
                    alive_next = 1'b0;
                end
            end
            CELL_SHIFT: begin
                entry_next = right_entry;
                alive_next = right_alive;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alive_reg <= 1'b0;
        end else begin
            alive_reg <= alive_next;
        end
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign alive = alive_reg;

endmodule

// ===== rtl/core/pareto_archive_insert.sv =====
// Top level of the Pareto archive: cell chain, sequencer and result register.
//
//   channel   direction  handshake            payload
//   s_        in         s_valid / s_ready    func, primary/secondary/check obj, tour id
//   m_        out        m_valid / m_ready    entry fields, count, overflow, last
//   cfg_      in         cfg_valid/cfg_ready  cfg_data (three-objective mode)
//
// An insert runs a sort step, then a prune pass over the n+1 cells in use (one
// head entry per cycle), a fixup step on overflow, then one beat per entry (a
// single beat when empty) while m_ready allows. A clear or duplicate skips pruning.
// Reset is synchronous and active low; the archive comes up empty.
// m_ready low holds the result register; a new item can be taken while the last beat waits.
module pareto_archive_insert (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic                                 cfg_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_func,
    input  logic signed [pai_pkg::OBJ_W-1:0]     s_primary_obj,
    input  logic signed [pai_pkg::OBJ_W-1:0]     s_secondary_obj,
    input  logic signed [pai_pkg::OBJ_W-1:0]     s_check_obj,
    input  logic        [pai_pkg::TOUR_W-1:0]    s_tour_id,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_entry_valid,
    output logic signed [pai_pkg::OBJ_W-1:0]     m_entry_primary,
    output logic signed [pai_pkg::OBJ_W-1:0]     m_entry_secondary,
    output logic signed [pai_pkg::OBJ_W-1:0]     m_entry_check,
    output logic        [pai_pkg::TOUR_W-1:0]    m_entry_tour,
    output logic        [pai_pkg::OUT_CNT_W-1:0] m_entry_count,
    output logic                                 m_overflow,
    output logic                                 m_last
);
    import pai_pkg::*;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [PTR_W-1:0]  tmp_reg, tmp_next;
    logic [PTR_W-1:0]  ptr_reg, ptr_next;
    logic [PTR_W-1:0]  pc_reg, pc_next;
    logic [PTR_W-1:0]  ins_reg, ins_next;
    logic              ovf_reg, ovf_next;
    logic              mode_reg;
    logic              func_reg;
    entry_t            np_reg;

    logic              m_valid_reg, m_valid_next;
    logic              m_ev_reg, m_ev_next;
    entry_t            m_e_reg, m_e_next;
    logic [CNT_W-1:0]  m_cnt_reg, m_cnt_next;
    logic              m_ovf_reg, m_ovf_next;
    logic              m_last_reg, m_last_next;

    entry_t            cell_entry [NCELL];
    logic              cell_alive [NCELL];
    logic              cell_gt    [NCELL];
    logic              cell_dup   [NCELL];
    cell_ctl_t         cell_ctl   [NCELL];
    entry_t            left_e     [NCELL];
    logic              left_g     [NCELL];
    entry_t            right_e    [NCELL];
    logic              right_a    [NCELL];

    entry_t            head;
    logic              head_alive;
    logic              dup_any;
    logic [PTR_W-1:0]  ins_pos;
    logic              load;
    logic              emit_last;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    assign head       = cell_entry[ptr_reg[IDX_W-1:0]];
    assign head_alive = cell_alive[ptr_reg[IDX_W-1:0]];

    // Neighbor links; the chain ends are tied off.
    always_comb begin
        for (int k = 0; k < NCELL; k++) begin
            left_e[k]  = (k == 0) ? np_reg : cell_entry[(k == 0) ? 0 : k - 1];
            left_g[k]  = (k == 0) ? 1'b0 : cell_gt[(k == 0) ? 0 : k - 1];
            right_e[k] = (k == NCELL - 1) ? cell_entry[k]
                                          : cell_entry[(k == NCELL - 1) ? k : k + 1];
            right_a[k] = (k == NCELL - 1) ? 1'b0
                                          : cell_alive[(k == NCELL - 1) ? k : k + 1];
        end
    end

    always_comb begin
        dup_any = 1'b0;
        ins_pos = '0;
        for (int k = 0; k < NCELL; k++) begin
            dup_any = dup_any | cell_dup[k];
            if (cell_gt[k] && !left_g[k]) begin
                ins_pos = ins_pos | PTR_W'(k);
            end
        end
    end

    always_comb begin
        for (int k = 0; k < NCELL; k++) begin
            cell_ctl[k].in_range = (k < int'(cnt_reg));
            cell_ctl[k].fill     = (k <= int'(cnt_reg));
            cell_ctl[k].op       = CELL_HOLD;
            unique case (state_reg)
                ST_INSERT: begin
                    if (func_reg == FUNC_INSERT && !dup_any) begin
                        cell_ctl[k].op = CELL_INSERT;
                    end
                end
                ST_PRUNE: begin
                    if (head_alive && k > int'(ptr_reg)) begin
                        cell_ctl[k].op = CELL_PRUNE;
                    end else if (!head_alive && k >= int'(ptr_reg)) begin
                        cell_ctl[k].op = CELL_SHIFT;
                    end
                end
                ST_FIXUP: begin
                    if (k >= int'(ins_reg)) begin
                        cell_ctl[k].op = CELL_SHIFT;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        pai_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctl         (cell_ctl[g]),
            .three_obj   (mode_reg),
            .np          (np_reg),
            .head        (head),
            .left_entry  (left_e[g]),
            .left_gt     (left_g[g]),
            .right_entry (right_e[g]),
            .right_alive (right_a[g]),
            .entry       (cell_entry[g]),
            .alive       (cell_alive[g]),
            .gt          (cell_gt[g]),
            .dup         (cell_dup[g])
        );
    end

    assign load      = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);
    assign emit_last = (cnt_reg == '0) || (ptr_reg + 1'b1 == PTR_W'(cnt_reg));

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        tmp_next     = tmp_reg;
        ptr_next     = ptr_reg;
        pc_next      = pc_reg;
        ins_next     = ins_reg;
        ovf_next     = ovf_reg;
        m_valid_next = m_valid_reg;
        m_ev_next    = m_ev_reg;
        m_e_next     = m_e_reg;
        m_cnt_next   = m_cnt_reg;
        m_ovf_next   = m_ovf_reg;
        m_last_next  = m_last_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_INSERT;
                end
            end
            ST_INSERT: begin
                ovf_next = 1'b0;
                ptr_next = '0;
                pc_next  = '0;
                if (func_reg == FUNC_CLEAR) begin
                    cnt_next   = '0;
                    state_next = ST_EMIT;
                end else if (dup_any) begin
                    state_next = ST_EMIT;
                end else begin
                    tmp_next   = PTR_W'(cnt_reg) + 1'b1;
                    ins_next   = ins_pos;
                    state_next = ST_PRUNE;
                end
            end
            ST_PRUNE: begin
                // A live head stays put; a dead one is squeezed out.
                ptr_next = ptr_reg + PTR_W'(head_alive);
                pc_next  = pc_reg + 1'b1;
                if (pc_reg + 1'b1 == tmp_reg) begin
                    if (ptr_next == PTR_W'(NCELL)) begin
                        state_next = ST_FIXUP;
                    end else begin
                        cnt_next   = ptr_next[CNT_W-1:0];
                        ptr_next   = '0;
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_FIXUP: begin
                // Drop the new point again; the archive stays as it was.
                ovf_next   = 1'b1;
                ptr_next   = '0;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (load) begin
                    m_valid_next = 1'b1;
                    m_ev_next    = (cnt_reg != '0);
                    m_e_next     = (cnt_reg != '0) ? head : '0;
                    m_cnt_next   = cnt_reg;
                    m_ovf_next   = ovf_reg;
                    m_last_next  = emit_last;
                    if (emit_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        ptr_next = ptr_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            tmp_reg     <= '0;
            ptr_reg     <= '0;
            pc_reg      <= '0;
            ins_reg     <= '0;
            ovf_reg     <= 1'b0;
            mode_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            tmp_reg     <= tmp_next;
            ptr_reg     <= ptr_next;
            pc_reg      <= pc_next;
            ins_reg     <= ins_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                mode_reg <= cfg_data;
            end
        end
        if (s_valid && s_ready) begin
            func_reg <= s_func;
            np_reg   <= '{p: s_primary_obj, s: s_secondary_obj, c: s_check_obj, t: s_tour_id};
        end
        m_ev_reg   <= m_ev_next;
        m_e_reg    <= m_e_next;
        m_cnt_reg  <= m_cnt_next;
        m_ovf_reg  <= m_ovf_next;
        m_last_reg <= m_last_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_entry_valid     = m_ev_reg;
    assign m_entry_primary   = m_e_reg.p;
    assign m_entry_secondary = m_e_reg.s;
    assign m_entry_check     = m_e_reg.c;
    assign m_entry_tour      = m_e_reg.t;
    assign m_entry_count     = OUT_CNT_W'(m_cnt_reg);
    assign m_overflow        = m_ovf_reg;
    assign m_last            = m_last_reg;

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(CAPACITY))
        else $error("archive count above capacity");

    a_ovf_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_ovf_reg) |-> (m_cnt_reg == CNT_W'(CAPACITY)))
        else $error("overflow flagged with archive not full");

    a_accept_sort: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_INSERT))
        else $error("accepted beat did not start the sort cycle");

    a_emit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && cnt_reg != '0) |-> (ptr_reg < PTR_W'(cnt_reg)))
        else $error("emit pointer past archive end");

endmodule
